// File: sv/lag_pkg.sv
// Package for the life automaton generation block.
// Holds grid constants, action codes and controller/datapath command types.
package lag_pkg;
   localparam int GRID_SIZE  = 256;
   localparam int COORD_W    = 8;
   localparam int ADDR_W     = 2 * COORD_W;
   localparam int MASK_W     = 9;
   localparam int CNT_W      = 4;

   typedef enum logic [1:0] {
      ACT_SET_ALIVE = 2'd0,
      ACT_SET_DEAD  = 2'd1,
      ACT_GENERATE  = 2'd2,
      ACT_READ      = 2'd3
   } action_type;

   localparam logic CSR_BIRTH = 1'b0;
   localparam logic CSR_DEATH = 1'b1;

   typedef struct packed {
      logic clear_sweep;   // write zeros through both memories
      logic do_write;      // single-cell write of the request
      logic gen_start;     // reset the sweep counter and change flag
      logic gen_step;      // advance the generation sweep one phase
      logic copy_step;     // copy next grid back one cell
      logic read_issue;    // read the addressed cell
   } lag_cmd_type;

   typedef struct packed {
      logic sweep_done;
      logic read_valid;
   } lag_status_type;
endpackage

// File: sv/lag_stream_if.sv
// Valid/ready channel interface carrying action, row and column, or results.
// No package dependency.
interface lag_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] cell_row;
   logic [7:0] cell_col;
   modport source (output valid, action, cell_row, cell_col, input ready);
   modport sink   (input valid, action, cell_row, cell_col, output ready);
endinterface

interface lag_rsp_if;
   logic valid;
   logic ready;
   logic cell_alive;
   logic grid_changed;
   modport source (output valid, cell_alive, grid_changed, input ready);
   modport sink   (input valid, cell_alive, grid_changed, output ready);
endinterface

// File: sv/lag_datapath.sv
// Datapath: grid memory, next-grid memory, neighbour counting and rule logic.
// Depends on lag_pkg.
module lag_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  lag_pkg::lag_cmd_type    cmd,
   output lag_pkg::lag_status_type status,
   input  logic [1:0]              req_action,
   input  logic [7:0]              req_row,
   input  logic [7:0]              req_col,
   input  logic [8:0]              birth_mask,
   input  logic [8:0]              death_mask,
   output logic                    cell_alive,
   output logic                    grid_changed
);
   import lag_pkg::*;

   // A generation steps each cell through phases 0..9: phases 0..8 read the 3x3
   // window through the single grid port, phase 9 takes the last read and
   // writes the new state to the next grid. Phase 4 reads the cell itself.
   localparam logic [ADDR_W-1:0] LAST = ADDR_W'(GRID_SIZE*GRID_SIZE-1);

   logic                 grid_mem [0:GRID_SIZE*GRID_SIZE-1];
   logic                 next_mem [0:GRID_SIZE*GRID_SIZE-1];

   logic [ADDR_W-1:0]    pos_ff, pos_in;
   logic [3:0]           ph_ff, ph_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 self_ff, self_in;
   logic                 chg_ff, chg_in;
   logic                 rd_ff;
   logic                 rdv_ff;
   logic                 copy_ff;
   logic                 copy_wr_ff;
   logic [ADDR_W-1:0]    copy_addr_ff;
   logic [COORD_W-1:0]   r, c, drow, dcol;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 interior, wr_ok, last_cell, new_cell;
   logic [CNT_W-1:0]     tot;

   assign r = pos_ff[ADDR_W-1:COORD_W];
   assign c = pos_ff[COORD_W-1:0];
   assign interior = r >= COORD_W'(1) && r < COORD_W'(GRID_SIZE-1)
                  && c >= COORD_W'(1) && c < COORD_W'(GRID_SIZE-1);
   assign wr_ok = req_row >= COORD_W'(1) && req_row < COORD_W'(GRID_SIZE-1)
               && req_col >= COORD_W'(1) && req_col < COORD_W'(GRID_SIZE-1);
   assign last_cell = (pos_ff == LAST);

   // neighbour offset per phase; addresses wrap only for border cells,
   // whose next state is forced dead anyway
   always_comb begin
      case (ph_ff)
         4'd0:    begin drow = '1;             dcol = '1;             end
         4'd1:    begin drow = '1;             dcol = '0;             end
         4'd2:    begin drow = '1;             dcol = COORD_W'(1);    end
         4'd3:    begin drow = '0;             dcol = '1;             end
         4'd4:    begin drow = '0;             dcol = '0;             end
         4'd5:    begin drow = '0;             dcol = COORD_W'(1);    end
         4'd6:    begin drow = COORD_W'(1);    dcol = '1;             end
         4'd7:    begin drow = COORD_W'(1);    dcol = '0;             end
         4'd8:    begin drow = COORD_W'(1);    dcol = COORD_W'(1);    end
         default: begin drow = '0;             dcol = '0;             end
      endcase
   end

   assign rd_addr = cmd.gen_step ? {r + drow, c + dcol} : {req_row, req_col};

   // read ports, registered
   always_ff @(posedge clock) begin
      if (cmd.gen_step || cmd.read_issue) rd_ff <= grid_mem[rd_addr];
      if (cmd.copy_step) copy_ff <= next_mem[pos_ff];
      copy_addr_ff <= pos_ff;
   end

   always_comb begin
      tot = cnt_ff + CNT_W'(rd_ff);
      if (self_ff)
         new_cell = interior && !death_mask[tot];
      else
         new_cell = interior && tot != '0 && birth_mask[tot];
   end

   always_comb begin
      pos_in  = pos_ff;
      ph_in   = ph_ff;
      cnt_in  = cnt_ff;
      self_in = self_ff;
      chg_in  = chg_ff;
      if (cmd.gen_start) begin
         pos_in = '0; ph_in = '0; cnt_in = '0; self_in = 1'b0; chg_in = 1'b0;
      end else if (cmd.gen_step) begin
         if (ph_ff == 4'd9) begin
            ph_in  = '0;
            cnt_in = '0;
            pos_in = pos_ff + ADDR_W'(1);
            if (new_cell != self_ff) chg_in = 1'b1;
         end else begin
            ph_in = ph_ff + 4'd1;
            // rd_ff holds the read of the previous phase
            if (ph_ff == 4'd5)      self_in = rd_ff;
            else if (ph_ff != 4'd0) cnt_in  = tot;
         end
      end else if (cmd.copy_step || cmd.clear_sweep) begin
         pos_in = pos_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_sweep) begin
         grid_mem[pos_ff] <= 1'b0;
      end else if (cmd.do_write && wr_ok) begin
         grid_mem[{req_row, req_col}] <= (req_action == ACT_SET_ALIVE);
      end else if (copy_wr_ff) begin
         grid_mem[copy_addr_ff] <= copy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_sweep) begin
         next_mem[pos_ff] <= 1'b0;
      end else if (cmd.gen_step && ph_ff == 4'd9) begin
         next_mem[pos_ff] <= new_cell;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; ph_ff <= '0; cnt_ff <= '0; self_ff <= 1'b0;
         chg_ff <= 1'b0; rdv_ff <= 1'b0; copy_wr_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         ph_ff      <= ph_in;
         cnt_ff     <= cnt_in;
         self_ff    <= self_in;
         chg_ff     <= chg_in;
         rdv_ff     <= cmd.read_issue;
         copy_wr_ff <= cmd.copy_step;
      end
   end

   assign status.sweep_done = last_cell && (cmd.clear_sweep || cmd.copy_step
                              || (cmd.gen_step && ph_ff == 4'd9));
   assign status.read_valid = rdv_ff;
   assign cell_alive   = rd_ff;
   assign grid_changed = chg_ff;
endmodule

// File: sv/lag_control.sv
// Controller: sequences the clearing pass after reset, then write, generation, copy and read per item.
// Depends on lag_pkg.
module lag_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_fire,
   input  logic [1:0]              req_action,
   input  lag_pkg::lag_status_type status,
   input  logic                    rsp_fire,
   output lag_pkg::lag_cmd_type    cmd,
   output logic                    req_ready,
   output logic                    rsp_valid,
   output logic                    is_gen
);
   import lag_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_GEN, ST_COPY, ST_COPY_END, ST_READ, ST_WAIT, ST_RSP
   } state_type;

   state_type state_ff, state_in;
   logic      gen_ff, gen_in;

   always_comb begin
      state_in = state_ff;
      gen_in   = gen_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_sweep = 1'b1;
            if (status.sweep_done) state_in = ST_IDLE;
         end
         ST_IDLE: if (req_fire) begin
            gen_in = (req_action == ACT_GENERATE);
            if (req_action == ACT_GENERATE) begin
               cmd.gen_start = 1'b1;
               state_in = ST_GEN;
            end else begin
               cmd.do_write = req_action inside {ACT_SET_ALIVE, ACT_SET_DEAD};
               state_in = ST_READ;
            end
         end
         ST_GEN: begin
            cmd.gen_step = 1'b1;
            if (status.sweep_done) state_in = ST_COPY;
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (status.sweep_done) state_in = ST_COPY_END;
         end
         ST_COPY_END: state_in = ST_READ;
         ST_READ: begin
            cmd.read_issue = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: state_in = ST_RSP;
         ST_RSP:  if (rsp_fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         gen_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         gen_ff   <= gen_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RSP);
   assign is_gen    = gen_ff;
endmodule

// File: sv/life_automaton_generation.sv
// Top level of the life automaton generation block.
// Depends on lag_pkg, lag_req_if/lag_rsp_if, lag_control, lag_datapath.
//  channel | dir | fields
//  req_    | in  | action, cell_row, cell_col
//  rsp_    | out | cell_alive, grid_changed
//  csr_    | in  | birth_mask (0), death_mask (1)
// Set/read items touch one cell; a generation steps each cell through its 3x3
// window via one grid memory port, then copies the next grid back.
// After reset a clearing pass zeroes both memories.
// One item at a time; rsp held until taken.
module life_automaton_generation (
   input  logic        clock,
   input  logic        reset,
   lag_req_if.sink     req,
   lag_rsp_if.source   rsp,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [8:0]  csr_write_data
);
   import lag_pkg::*;

   lag_cmd_type    cmd;
   lag_status_type status;
   logic [8:0]     birth_ff, death_ff;
   logic [1:0]     act_ff;
   logic [7:0]     row_ff, col_ff;
   logic           is_gen, alive, chg;

   always_ff @(posedge clock) begin
      if (reset) begin
         birth_ff <= 9'd8;
         death_ff <= 9'd499;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_BIRTH) birth_ff <= csr_write_data;
         else                        death_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         act_ff <= req.action;
         row_ff <= req.cell_row;
         col_ff <= req.cell_col;
      end
   end

   lag_control u_ctl (
      .clock, .reset,
      .req_fire  (req.valid && req.ready),
      .req_action(req.action),
      .status,
      .rsp_fire  (rsp.valid && rsp.ready),
      .cmd,
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .is_gen
   );

   lag_datapath u_dp (
      .clock, .reset, .cmd, .status,
      .req_action(cmd.do_write ? req.action : act_ff),
      .req_row   (cmd.do_write ? req.cell_row : row_ff),
      .req_col   (cmd.do_write ? req.cell_col : col_ff),
      .birth_mask(birth_ff),
      .death_mask(death_ff),
      .cell_alive(alive),
      .grid_changed(chg)
   );

   logic alive_ff;
   always_ff @(posedge clock) if (status.read_valid) alive_ff <= alive;

   assign rsp.cell_alive   = alive_ff;
   assign rsp.grid_changed = is_gen & chg;
endmodule
